### hdl/clw_pkg.sv
// Shared types, constants and codes for the CPU load window meter.
package clw_pkg;

  localparam int MAX_CPUS = 8;
  localparam int CPU_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  localparam int DIV_W = 64;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_CLOCK_HZ = 1'b1;

  localparam logic [3:0] ACTIVE_CPUS_RESET = 4'd8;
  localparam logic [31:0] CYCLE_CLOCK_HZ_RESET = 32'd100000000;

  localparam logic [19:0] MICROS_PER_SECOND = 20'd1000000;
  localparam logic [6:0] FULL_LOAD = 7'd100;
  localparam logic [6:0] FULL_CONFIDENCE = 7'd100;
  localparam logic [63:0] LOAD_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF / 64'd100;
  localparam logic [63:0] MICROS_Q_LIMIT = 64'h0000_0000_FFFF_FFFF / 64'd1000000;

  // Dividing the window by 100 goes 16 bits at a time: a 23-bit partial value times
  // ceil(2^30 / 100), shifted down by 30, is its exact quotient by 100.
  localparam logic [22:0] STEP_DIVISOR = 23'd100;
  localparam logic [23:0] STEP_RECIP = 24'd10737419;
  localparam int STEP_SHIFT = 30;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RETRY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LM_FULL,
    LM_SCALED,
    LM_STEP
  } load_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LAUNCH1,
    S_WAIT1,
    S_MUL,
    S_LAUNCH2,
    S_WAIT2,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]  cpu_index;
    logic [63:0] elapsed_cycles_total;
    logic [63:0] busy_cycles_total;
  } query_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] busy_delta;
    logic [63:0] window_delta;
    logic [31:0] window_micros;
    logic [6:0]  load_percent;
    logic [6:0]  confidence;
  } result_t;

  typedef struct packed {
    logic [63:0] elapsed;
    logic [63:0] busy;
  } base_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

endpackage

### hdl/clw_base_ram.sv
// Baseline counter memory: one elapsed/busy pair per CPU, with a registered read.
module clw_base_ram (
  input  logic                     clk,
  input  logic                     we,
  input  logic [clw_pkg::CPU_W-1:0] waddr,
  input  clw_pkg::base_t           wdata,
  input  logic                     re,
  input  logic [clw_pkg::CPU_W-1:0] raddr,
  output clw_pkg::base_t           rdata
);

  clw_pkg::base_t mem [clw_pkg::MAX_CPUS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/clw_div.sv
// Restoring 64-bit divider that retires one quotient bit per cycle.
module clw_div (
  input  logic              clk,
  input  logic              rst,
  input  clw_pkg::div_req_t req,
  output logic              active,
  output logic [63:0]       quot,
  output logic [63:0]       rem
);

  logic [63:0]                  dsr;
  logic [clw_pkg::DIV_CNT_W-1:0] count;
  logic [64:0]                  trial;
  logic [64:0]                  diff;

  assign trial = {rem, quot[63]};
  assign diff = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      active <= 1'b1;
      count <= '0;
    end else if (active) begin
      count <= count + 1'b1;
      if (count == clw_pkg::DIV_CNT_W'(clw_pkg::DIV_W - 1)) begin
        active <= 1'b0;
      end
    end
  end

  // The quotient register starts out holding the dividend and shifts quotient bits in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (active) begin
      if (!diff[64]) begin
        rem <= diff[63:0];
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem <= trial[63:0];
        quot <= {quot[62:0], 1'b0};
      end
    end
  end

endmodule

### hdl/cpu_load_window_percent.sv
// Top level of the CPU load window meter: sequencer, configuration and result register.
//
// A query is taken when start is high and busy is low; its result word appears on result
// with done high for exactly one cycle, and the receiver cannot stall it. Invalid-CPU and
// retry results are decided in the evaluation state that follows the taken query. For an
// OK result, a first wait runs the bit-serial divide of the window by the clock rate,
// next to the division of the window by 100 and, when busy is below the window and small
// enough to scale by 100, the load divide; a second wait runs the microsecond remainder
// divide and, for very large busy counts, busy over a hundredth of the window. Baseline
// memory access and bookkeeping fill the states around the waits. When the microsecond
// count saturates and no large-busy divide is needed, no divider is started for the
// second wait and it passes straight on. Busy stays low while a result is shown, so the
// next query can be taken in that cycle. Baselines live in a small memory; only the
// per-CPU valid flags are cleared at reset, so no clearing pass is needed.
module cpu_load_window_percent (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  clw_pkg::query_t               query,
  input  logic                          cfg_write,
  input  logic [clw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          done,
  output clw_pkg::result_t              result
);

  clw_pkg::state_t state;
  clw_pkg::state_t state_next;

  logic [3:0]  active_cpus;
  logic [31:0] cycle_clock_hz;

  clw_pkg::query_t  req;
  clw_pkg::base_t   base_rd;
  clw_pkg::base_t   base_wr;
  logic [clw_pkg::MAX_CPUS-1:0] has_base;
  logic [clw_pkg::CPU_W-1:0] addr;

  logic [63:0] win;
  logic [63:0] busy_d;
  logic [63:0] prod;
  logic [32:0] us_hi;
  logic        us_sat;
  logic [6:0]  load_pct;
  logic        b2_needed;
  clw_pkg::load_mode_t load_mode;
  clw_pkg::load_mode_t load_mode_next;

  logic [63:0] step_quot;
  logic [6:0]  step_rem;
  logic [2:0]  step_cnt;
  logic [15:0] step_chunk;
  logic [22:0] step_part;
  logic [46:0] step_prod;
  logic [15:0] step_digit;
  logic [22:0] step_diff;

  clw_pkg::div_req_t a_req;
  clw_pkg::div_req_t b_req;
  logic        a_active;
  logic        b_active;
  logic [63:0] a_quot;
  logic [63:0] a_rem;
  logic [63:0] b_quot;
  logic [63:0] b_rem;

  logic        accept;
  logic        cpu_ok;
  logic        went_back;
  logic [63:0] win_c;
  logic [63:0] busy_c;
  logic [63:0] hz_eff;
  logic        ram_we;
  logic        emit;
  clw_pkg::result_t result_next;
  logic [33:0] us_sum;

  assign busy = (state != clw_pkg::S_IDLE);
  assign accept = start && !busy;
  assign addr = req.cpu_index[clw_pkg::CPU_W-1:0];
  assign hz_eff = (cycle_clock_hz == 32'd0) ? 64'd1 : {32'd0, cycle_clock_hz};

  assign cpu_ok = (req.cpu_index < {4'd0, active_cpus}) &&
                  (req.cpu_index < 8'(clw_pkg::MAX_CPUS));
  assign went_back = (req.elapsed_cycles_total < base_rd.elapsed) ||
                     (req.busy_cycles_total < base_rd.busy);
  assign win_c = req.elapsed_cycles_total - base_rd.elapsed;
  assign busy_c = req.busy_cycles_total - base_rd.busy;
  assign base_wr = '{elapsed: req.elapsed_cycles_total, busy: req.busy_cycles_total};
  assign us_sum = {1'b0, us_hi} + {14'd0, a_quot[19:0]};

  // The window is divided by 100 one 16-bit digit per cycle, most significant first.
  assign step_part = {step_rem, step_chunk};
  assign step_prod = 47'(step_part) * 47'(clw_pkg::STEP_RECIP);
  assign step_digit = step_prod[clw_pkg::STEP_SHIFT+15:clw_pkg::STEP_SHIFT];
  assign step_diff = step_part - 23'(step_digit) * clw_pkg::STEP_DIVISOR;

  always_comb begin
    unique case (step_cnt[1:0])
      2'd0: step_chunk = win[63:48];
      2'd1: step_chunk = win[47:32];
      2'd2: step_chunk = win[31:16];
      default: step_chunk = win[15:0];
    endcase
  end

  // One query is in flight at a time and its write-back lands before the next read, so
  // the memory needs no forwarding.
  clw_base_ram u_base_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (base_wr),
    .re    (accept),
    .raddr (query.cpu_index[clw_pkg::CPU_W-1:0]),
    .rdata (base_rd)
  );

  clw_div u_div_micros (
    .clk    (clk),
    .rst    (rst),
    .req    (a_req),
    .active (a_active),
    .quot   (a_quot),
    .rem    (a_rem)
  );

  clw_div u_div_load (
    .clk    (clk),
    .rst    (rst),
    .req    (b_req),
    .active (b_active),
    .quot   (b_quot),
    .rem    (b_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cpus <= clw_pkg::ACTIVE_CPUS_RESET;
      cycle_clock_hz <= clw_pkg::CYCLE_CLOCK_HZ_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        clw_pkg::CFG_ACTIVE_CPUS: active_cpus <= cfg_data[3:0];
        clw_pkg::CFG_CYCLE_CLOCK_HZ: cycle_clock_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    a_req = '{start: 1'b0, dividend: win, divisor: hz_eff};
    b_req = '{start: 1'b0, dividend: busy_d, divisor: win};
    load_mode_next = load_mode;
    ram_we = 1'b0;
    emit = 1'b0;
    result_next = '0;
    unique case (state)
      clw_pkg::S_IDLE: begin
        if (accept) begin
          state_next = clw_pkg::S_EVAL;
        end
      end
      clw_pkg::S_EVAL: begin
        if (!cpu_ok) begin
          emit = 1'b1;
          result_next.status = clw_pkg::ST_INVALID;
          state_next = clw_pkg::S_IDLE;
        end else if (!has_base[addr] || went_back || win_c == 64'd0) begin
          ram_we = 1'b1;
          emit = 1'b1;
          result_next.status = clw_pkg::ST_RETRY;
          state_next = clw_pkg::S_IDLE;
        end else begin
          ram_we = 1'b1;
          state_next = clw_pkg::S_LAUNCH1;
        end
      end
      clw_pkg::S_LAUNCH1: begin
        a_req.start = 1'b1;
        if (busy_d >= win) begin
          load_mode_next = clw_pkg::LM_FULL;
        end else if (busy_d <= clw_pkg::LOAD_LIMIT) begin
          load_mode_next = clw_pkg::LM_SCALED;
          b_req.start = 1'b1;
          b_req.dividend = 64'(busy_d * 64'd100);
        end else begin
          // Large busy counts divide by the window's hundredth to stay within 64 bits;
          // that hundredth is worked out during the first wait.
          load_mode_next = clw_pkg::LM_STEP;
        end
        state_next = clw_pkg::S_WAIT1;
      end
      clw_pkg::S_WAIT1: begin
        if (!a_active && !b_active && step_cnt[2]) begin
          state_next = clw_pkg::S_MUL;
        end
      end
      clw_pkg::S_MUL: begin
        state_next = clw_pkg::S_LAUNCH2;
      end
      clw_pkg::S_LAUNCH2: begin
        a_req.start = !us_sat;
        a_req.dividend = prod;
        b_req.start = b2_needed;
        b_req.divisor = step_quot;
        state_next = clw_pkg::S_WAIT2;
      end
      clw_pkg::S_WAIT2: begin
        if (!a_active && !b_active) begin
          state_next = clw_pkg::S_FINISH;
        end
      end
      clw_pkg::S_FINISH: begin
        emit = 1'b1;
        result_next.status = clw_pkg::ST_OK;
        result_next.busy_delta = busy_d;
        result_next.window_delta = win;
        if (us_sat || us_sum[33:32] != 2'd0) begin
          result_next.window_micros = 32'hFFFF_FFFF;
        end else begin
          result_next.window_micros = us_sum[31:0];
        end
        if (b2_needed) begin
          result_next.load_percent = (b_quot > 64'd100) ? clw_pkg::FULL_LOAD : b_quot[6:0];
        end else begin
          result_next.load_percent = load_pct;
        end
        result_next.confidence = clw_pkg::FULL_CONFIDENCE;
        state_next = clw_pkg::S_IDLE;
      end
      default: state_next = clw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_base <= '0;
      done <= 1'b0;
    end else begin
      done <= emit;
      if (ram_we) begin
        has_base[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= query;
    end
    if (emit) begin
      result <= result_next;
    end
    if (state == clw_pkg::S_EVAL) begin
      win <= win_c;
      busy_d <= busy_c;
    end
    if (state == clw_pkg::S_LAUNCH1) begin
      load_mode <= load_mode_next;
      step_cnt <= '0;
      step_rem <= '0;
    end
    // Four digits are taken while the first divisions run; the top count bit marks the end.
    if (state == clw_pkg::S_WAIT1 && !step_cnt[2]) begin
      step_quot <= {step_quot[47:0], step_digit};
      step_rem <= step_diff[6:0];
      step_cnt <= step_cnt + 3'd1;
    end
    if (state == clw_pkg::S_MUL) begin
      // The whole-second part of the window is scaled here; the remainder goes to the
      // second division.
      us_sat <= (a_quot > clw_pkg::MICROS_Q_LIMIT);
      us_hi <= 33'(a_quot[12:0]) * 33'(clw_pkg::MICROS_PER_SECOND);
      prod <= 64'(52'(a_rem[31:0]) * 52'(clw_pkg::MICROS_PER_SECOND));
      b2_needed <= (load_mode == clw_pkg::LM_STEP) && (step_quot != 64'd0);
      unique case (load_mode)
        clw_pkg::LM_SCALED: load_pct <= b_quot[6:0];
        clw_pkg::LM_FULL,
        clw_pkg::LM_STEP: load_pct <= clw_pkg::FULL_LOAD;
        default: load_pct <= clw_pkg::FULL_LOAD;
      endcase
    end
  end

endmodule

### tb/sv/cpu_load_window_percent_tb.sv
// Self-checking testbench for the CPU load window meter, with a scoreboard that predicts each word.
module cpu_load_window_percent_tb;
  import clw_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 195;
  localparam int PRINT_CAP = 200;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SCALED_CAP = ALL_ONES / 64'd100;
  localparam logic [63:0] USEC_PER_SEC = 64'd1000000;
  localparam logic [63:0] SECONDS_CAP = 64'h0000_0000_FFFF_FFFF / USEC_PER_SEC;
  localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [6:0] PERCENT_FULL = 7'd100;

  class load_scoreboard;
    logic [3:0] active_cpus;
    logic [31:0] clock_hz;
    logic [63:0] base_el[MAX_CPUS];
    logic [63:0] base_bu[MAX_CPUS];
    bit seen[MAX_CPUS];
    result_t expected_q[$];
    int errors;
    int n_ok;
    int n_retry;
    int n_invalid;

    function new();
      active_cpus = ACTIVE_CPUS_RESET;
      clock_hz = CYCLE_CLOCK_HZ_RESET;
      foreach (seen[i]) seen[i] = 1'b0;
      errors = 0;
      n_ok = 0;
      n_retry = 0;
      n_invalid = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function logic [6:0] load_pct(logic [63:0] bsy, logic [63:0] win);
      logic [63:0] step;
      logic [63:0] q;
      if (bsy >= win) return PERCENT_FULL;
      if (bsy <= SCALED_CAP) return 7'((bsy * 64'd100) / win);
      // Busy is too large to scale by 100, so divide by a hundredth of the window instead.
      step = win / 64'd100;
      q = bsy / step;
      return (q > 64'd100) ? PERCENT_FULL : q[6:0];
    endfunction

    function logic [31:0] window_usec(logic [63:0] win);
      logic [63:0] hz;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] us;
      hz = (clock_hz == 32'd0) ? 64'd1 : {32'd0, clock_hz};
      q = win / hz;
      r = win % hz;
      if (q > SECONDS_CAP) return U32_MAX[31:0];
      us = q * USEC_PER_SEC + (r * USEC_PER_SEC) / hz;
      return (us > U32_MAX) ? U32_MAX[31:0] : us[31:0];
    endfunction

    function void note_query(query_t q);
      result_t r;
      logic [63:0] win;
      logic [63:0] bsy;
      int c;
      r = '0;
      c = int'(q.cpu_index);
      if (q.cpu_index >= {4'd0, active_cpus} || c >= MAX_CPUS) begin
        r.status = ST_INVALID;
      end else if (!seen[c] || q.elapsed_cycles_total < base_el[c] ||
                   q.busy_cycles_total < base_bu[c]) begin
        base_el[c] = q.elapsed_cycles_total;
        base_bu[c] = q.busy_cycles_total;
        seen[c] = 1'b1;
        r.status = ST_RETRY;
      end else begin
        win = q.elapsed_cycles_total - base_el[c];
        bsy = q.busy_cycles_total - base_bu[c];
        base_el[c] = q.elapsed_cycles_total;
        base_bu[c] = q.busy_cycles_total;
        if (win == 64'd0) begin
          r.status = ST_RETRY;
        end else begin
          r.status = ST_OK;
          r.busy_delta = bsy;
          r.window_delta = win;
          r.window_micros = window_usec(win);
          r.load_percent = load_pct(bsy, win);
          r.confidence = FULL_CONFIDENCE;
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (errors < PRINT_CAP)
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("word with no query outstanding", 64'(got.status), 64'd0);
      end else begin
        want = expected_q.pop_front();
        case (want.status)
          ST_OK: n_ok++;
          ST_RETRY: n_retry++;
          default: n_invalid++;
        endcase
        if (got.status !== want.status)
          report("status", 64'(got.status), 64'(want.status));
        if (got.busy_delta !== want.busy_delta)
          report("busy_delta", got.busy_delta, want.busy_delta);
        if (got.window_delta !== want.window_delta)
          report("window_delta", got.window_delta, want.window_delta);
        if (got.window_micros !== want.window_micros)
          report("window_micros", 64'(got.window_micros), 64'(want.window_micros));
        if (got.load_percent !== want.load_percent)
          report("load_percent", 64'(got.load_percent), 64'(want.load_percent));
        if (got.confidence !== want.confidence)
          report("confidence", 64'(got.confidence), 64'(want.confidence));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  query_t query;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic done;
  result_t result;

  load_scoreboard sb;
  int stall_cycles;
  int settings_used;
  logic [63:0] shadow_el[MAX_CPUS];
  logic [63:0] shadow_bu[MAX_CPUS];

  cpu_load_window_percent u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .query(query),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .result(result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_query(query);
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("cpu_load_window_percent_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic query_t make_query(logic [7:0] cpu, logic [63:0] el, logic [63:0] bu);
    query_t q;
    q.cpu_index = cpu;
    q.elapsed_cycles_total = el;
    q.busy_cycles_total = bu;
    return q;
  endfunction

  // Most words continue a CPU's counter sequence; the rest are rejected CPUs,
  // counters that step back, restarts and empty windows.
  function automatic query_t gen_query();
    query_t q;
    logic [63:0] el;
    logic [63:0] bu;
    logic [63:0] win;
    logic [63:0] bsy;
    int unsigned c;
    int unsigned m;
    if ($urandom_range(0, 99) < 8) begin
      q.cpu_index = 8'($urandom_range(MAX_CPUS, 255));
      q.elapsed_cycles_total = rand64();
      q.busy_cycles_total = rand64();
      return q;
    end
    c = $urandom_range(0, MAX_CPUS - 1);
    el = shadow_el[c];
    bu = shadow_bu[c];
    m = $urandom_range(0, 99);
    if (m < 6) begin
      if ($urandom_range(0, 1) == 1) el = el - (rand64() >> $urandom_range(32, 63)) - 64'd1;
      else bu = bu - (rand64() >> $urandom_range(32, 63)) - 64'd1;
    end else if (m < 10) begin
      el = rand64() >> $urandom_range(0, 63);
      bu = rand64() >> $urandom_range(0, 63);
    end else if (m < 14) begin
      bu = bu + (rand64() >> $urandom_range(40, 63));
    end else begin
      win = rand64() >> $urandom_range(0, 63);
      if (win == 64'd0) win = 64'd1;
      m = $urandom_range(0, 99);
      if (m < 70) bsy = (win == ALL_ONES) ? rand64() : rand64() % (win + 64'd1);
      else if (m < 85) bsy = win + (rand64() >> $urandom_range(48, 63));
      else bsy = rand64() >> $urandom_range(0, 63);
      el = el + win;
      bu = bu + bsy;
    end
    q.cpu_index = 8'(c);
    q.elapsed_cycles_total = el;
    q.busy_cycles_total = bu;
    return q;
  endfunction

  // Holds the word on the port until the block takes it.
  task automatic send(query_t q);
    start <= 1'b1;
    query <= q;
    if (q.cpu_index < MAX_CPUS) begin
      shadow_el[q.cpu_index] = q.elapsed_cycles_total;
      shadow_bu[q.cpu_index] = q.busy_cycles_total;
    end
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [3:0] cpus, logic [31:0] hz);
    cfg_write <= 1'b1;
    cfg_index <= CFG_ACTIVE_CPUS;
    cfg_data <= {28'd0, cpus};
    @(posedge clk);
    cfg_index <= CFG_CYCLE_CLOCK_HZ;
    cfg_data <= hz;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.active_cpus = cpus;
    sb.clock_hz = hz;
    settings_used++;
  endtask

  // Runs at the reset settings: 8 CPUs and a 100 MHz counter.
  task automatic directed_queries();
    send(make_query(8'hFF, ALL_ONES, ALL_ONES));
    send(make_query(8'd8, 64'd5, 64'd5));
    send(make_query(8'd0, 64'd0, 64'd0));
    send(make_query(8'd0, 64'd0, 64'd0));
    send(make_query(8'd0, 64'd1000, 64'd500));
    send(make_query(8'd0, 64'd2000, 64'd2500));
    send(make_query(8'd0, 64'd1500, 64'd3000));
    send(make_query(8'd0, 64'd1600, 64'd100));
    send(make_query(8'd0, 64'd1700, 64'd100));
    send(make_query(8'd1, 64'd0, 64'd0));
    send(make_query(8'd1, ALL_ONES, ALL_ONES - 64'd1));
    send(make_query(8'd2, 64'd0, 64'd0));
    send(make_query(8'd2, 64'h8000_0000_0000_0000, SCALED_CAP + 64'd1));
    send(make_query(8'd2, 64'h8000_0000_0000_0000 + SCALED_CAP + 64'd1,
                    SCALED_CAP + 64'd1 + SCALED_CAP));
    // Windows right at and just past the 32-bit microsecond limit.
    send(make_query(8'd3, 64'd50, 64'd7));
    send(make_query(8'd3, 64'd429496729550, 64'd8));
    send(make_query(8'd3, 64'd858996729549, 64'd9));
    send(make_query(8'd3, 64'd1288496729549, 64'd10));
    send(make_query(8'd7, ALL_ONES, ALL_ONES));
    send(make_query(8'd7, ALL_ONES, ALL_ONES));
    send(make_query(8'd7, 64'd0, 64'd0));
    send(make_query(8'd6, 64'd1, 64'd0));
    send(make_query(8'd6, 64'd2, 64'd0));
    send(make_query(8'd5, 64'd0, ALL_ONES));
    send(make_query(8'd5, 64'd100, ALL_ONES));
  endtask

  task automatic random_phase(int n, bit calm);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        drain_results();
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      send(gen_query());
    end
  endtask

  initial begin
    logic [3:0] cpus;
    logic [31:0] hz;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    query = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_cycles = 0;
    settings_used = 1;
    foreach (shadow_el[i]) begin
      shadow_el[i] = 64'd0;
      shadow_bu[i] = 64'd0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_queries();
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin cpus = 4'd8; hz = 32'd1; end
        1: begin cpus = 4'd1; hz = 32'hFFFF_FFFF; end
        2: begin cpus = 4'd8; hz = 32'd1000000; end
        default: begin
          cpus = 4'($urandom_range(1, MAX_CPUS));
          case ($urandom_range(0, 3))
            0: hz = $urandom_range(1, 1000);
            1: hz = $urandom_range(1000000, 200000000);
            default: hz = $urandom;
          endcase
          if (hz == 32'd0) hz = 32'd1;
        end
      endcase
      write_config(cpus, hz);
      random_phase(PHASE_ITEMS, p == 2);
    end
    drain_results();

    $display("ran %0d queries over %0d register settings: %0d ok, %0d retry, %0d invalid cpu",
             sb.n_ok + sb.n_retry + sb.n_invalid, settings_used, sb.n_ok, sb.n_retry,
             sb.n_invalid);
    if (sb.errors == 0) begin
      $display("cpu_load_window_percent_tb: PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("cpu_load_window_percent_tb: FAIL");
    end
    $finish;
  end

endmodule
